[sv/ngs_pkg.sv]
package ngs_pkg;

   // Widths fixed by the transaction fields.
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;
   localparam int STAT_W  = 2;
   localparam int RES_W   = 12;

   // Cell write addresses are carried at the width of the largest store.
   localparam int ADDR_W = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [RES_W-1:0] left_greater;
      logic signed [RES_W-1:0] right_greater;
   } rsp_type;

   // Control broadcast from the sequencer to every cell of the ring.
   typedef struct packed {
      logic                      shift;
      logic                      write;
      logic [ADDR_W-1:0]         addr;
      logic signed [VALUE_W-1:0] data;
   } cell_ctl_type;

endpackage

[sv/ngs_cell.sv]
module ngs_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  ngs_pkg::cell_ctl_type         ctl,
   input  logic signed [31:0]            neighbor_value,
   output logic signed [31:0]            value
);
   import ngs_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      selected;

   // A write lands only in the cell whose physical slot is addressed.
   assign selected = ctl.write && (ctl.addr == ADDR_W'(CELL_IDX));

   // The ring rotates by one slot when shifting; writes happen only while it stands.
   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = neighbor_value;
      end else if (selected) begin
         value_in = ctl.data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[sv/ngs_ctrl.sv]
module ngs_ctrl #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ngs_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ngs_pkg::rsp_type      rsp_data,
   input  logic signed [31:0]    head_value,
   output ngs_pkg::cell_ctl_type cell_ctl
);
   import ngs_pkg::*;

   localparam int IDX_W = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SEEK = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          head_idx_ff, head_idx_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]          steps_ff, steps_in;
   logic signed [RES_W-1:0]   left_ff, left_in;
   logic signed [RES_W-1:0]   right_ff, right_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      out_free;
   logic [IDX_W-1:0]          head_next;
   logic [CNT_W-1:0]          head_plus1;
   logic [SUM_W-1:0]          wr_addr;
   logic                      head_greater;

   // The output register is free when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;

   // Logical index of the element at the head after one more rotation.
   assign head_next  = (head_idx_ff == IDX_W'(MAX_ITEMS - 1)) ? '0 : head_idx_ff + IDX_W'(1);
   assign head_plus1 = CNT_W'(head_idx_ff) + CNT_W'(1);

   // Physical slot of the next appended element, given the ring's rotation.
   always_comb begin
      if (count_ff >= CNT_W'(head_idx_ff)) begin
         wr_addr = SUM_W'(count_ff) - SUM_W'(head_idx_ff);
      end else begin
         wr_addr = SUM_W'(count_ff) + SUM_W'(MAX_ITEMS) - SUM_W'(head_idx_ff);
      end
   end

   assign head_greater = head_value > key_ff;

   // Sequencer: takes transactions, rotates the ring and builds responses.
   always_comb begin
      state_in     = state_ff;
      head_idx_in  = head_idx_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      steps_in     = steps_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cell_ctl       = '0;
      cell_ctl.addr  = ADDR_W'(wr_addr);
      cell_ctl.data  = req_data.value;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = STAT_OK;
               rsp_data_in.left_greater   = '0;
               rsp_data_in.right_greater  = '0;
               case (req_data.kind)
                  KIND_APPEND: begin
                     if (count_ff < CNT_W'(MAX_ITEMS)) begin
                        cell_ctl.write = 1'b1;
                        count_in       = count_ff + CNT_W'(1);
                     end else begin
                        rsp_data_in.status = STAT_FULL;
                     end
                  end
                  KIND_QUERY: begin
                     if (CMP_W'(req_data.position) >= CMP_W'(count_ff)) begin
                        rsp_data_in.status = STAT_RANGE;
                     end else begin
                        // The response comes after the ring has been scanned.
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        rsp_data_in  = rsp_data_ff;
                        pos_in       = IDX_W'(req_data.position);
                        state_in     = ST_SEEK;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEEK: begin
            // Rotate until the queried element sits at the head, then latch it.
            cell_ctl.shift = 1'b1;
            head_idx_in    = head_next;
            if (head_idx_ff == pos_ff) begin
               key_in   = head_value;
               steps_in = '0;
               left_in  = '1;
               right_in = '1;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Every other slot passes the head once, in rising index order
            // from just after the queried position, wrapping around.
            cell_ctl.shift = 1'b1;
            head_idx_in    = head_next;
            steps_in       = steps_ff + CNT_W'(1);
            if (head_idx_ff < pos_ff) begin
               if (head_greater) begin
                  left_in = RES_W'(head_plus1);
               end
            end else if (head_idx_ff > pos_ff && CNT_W'(head_idx_ff) < count_ff) begin
               if (head_greater && !found_ff) begin
                  right_in = RES_W'(head_plus1);
                  found_in = 1'b1;
               end
            end
            if (steps_ff == CNT_W'(MAX_ITEMS - 2)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = STAT_OK;
               rsp_data_in.left_greater  = left_ff;
               rsp_data_in.right_greater = right_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_idx_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_idx_ff  <= head_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      steps_ff    <= steps_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/nearest_greater_search.sv]
// Nearest greater search over a store of up to MAX_ITEMS signed 32-bit values,
// held in a ring of cells that rotates past one compare point at the head.
// An append, a clear, an unused kind, a full-store append and an out-of-range
// query each load the response register when the request is taken. A valid
// query first rotates the ring until the queried element reaches the head,
// then rotates on so that every other slot passes the head compare once, and
// then loads the response once the output register is free. The ring moves
// one slot per cycle while a query rotates it.
// A new request is taken only while no query is in progress and the output
// register is either empty or being read in the same cycle.
module nearest_greater_search #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ngs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ngs_pkg::rsp_type rsp_data
);
   import ngs_pkg::*;

   cell_ctl_type              cell_ctl;
   logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];

   // Sequencer with the element count, ring rotation and response register.
   ngs_ctrl #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .head_value (cell_value[0]),
      .cell_ctl   (cell_ctl)
   );

   // Ring of storage cells: each one takes its right neighbor's value on a shift.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_ITEMS;
      ngs_cell #(
         .CELL_IDX(i)
      ) u_cell (
         .clock          (clock),
         .ctl            (cell_ctl),
         .neighbor_value (cell_value[NEXT]),
         .value          (cell_value[i])
      );
   end

endmodule
